// ===== src/local_binary_pattern_3x3_macros.svh =====
// Assertion macros for the 3x3 local binary pattern block.
// Used by the top level only; no other dependencies.
`ifndef LOCAL_BINARY_PATTERN_3X3_MACROS_SVH
`define LOCAL_BINARY_PATTERN_3X3_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LBP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbp3x3 same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbp3x3 next-cycle check failed");

`endif

// ===== src/lbp3x3_pkg.sv =====
// Shared constants and types for the 3x3 local binary pattern block.
// No dependencies.
package lbp3x3_pkg;

    localparam int PIXEL_W       = 8;
    localparam int CODE_W        = 8;
    localparam int ROW_W         = 12;
    localparam int COL_W         = 11;
    localparam int CFG_WIDTH_W   = 12;
    localparam int CFG_HEIGHT_W  = 13;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_IDX_W     = 1;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;
    localparam int MIN_SIZE      = 3;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MAX_WIDTH_DEF = 2048;

    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_CNT_W    = 3;

    typedef struct packed {
        logic             emit;
        logic             last;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_pos;

    typedef struct packed {
        logic              last;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CODE_W-1:0] code;
    } t_result;

endpackage

// ===== src/lbp3x3_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
// Read returns the old contents on a same-address write. No dependencies.
module lbp3x3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lbp3x3_pos_ctr.sv =====
// Size registers and raster position counters for the LBP block.
// Depends on lbp3x3_pkg.
module lbp3x3_pos_ctr #(
    parameter int MAX_WIDTH = lbp3x3_pkg::MAX_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lbp3x3_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lbp3x3_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_advance,
    input  logic                             i_frame_start,
    output logic [$clog2(MAX_WIDTH)-1:0]     o_addr,
    output lbp3x3_pkg::t_pos                 o_pos
);
    import lbp3x3_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int CWW = CW + 1;

    function automatic logic [CWW-1:0] clamp_width(input logic [CFG_WIDTH_W-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        if (t < 32'(MIN_SIZE)) t = 32'(MIN_SIZE);
        if (t > 32'(MAX_WIDTH)) t = 32'(MAX_WIDTH);
        return CWW'(t);
    endfunction

    function automatic logic [CFG_HEIGHT_W-1:0] clamp_height(
        input logic [CFG_HEIGHT_W-1:0] v
    );
        logic [31:0] t;
        t = 32'(v);
        if (t < 32'(MIN_SIZE)) t = 32'(MIN_SIZE);
        if (t > 32'(MAX_HEIGHT)) t = 32'(MAX_HEIGHT);
        return CFG_HEIGHT_W'(t);
    endfunction

    logic [CWW-1:0]          r_w_eff;
    logic [CFG_HEIGHT_W-1:0] r_h_eff;
    logic [CW-1:0]           r_col, n_col, col_now, col_m1;
    logic [ROW_W-1:0]        r_row, n_row, row_now;
    logic [CWW-1:0]          col_inc, w_last;
    logic [CFG_HEIGHT_W-1:0] row_inc, h_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_eff <= clamp_width(CFG_WIDTH_W'(WIDTH_RESET));
            r_h_eff <= clamp_height(CFG_HEIGHT_W'(HEIGHT_RESET));
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_w_eff <= clamp_width(i_cfg_data[CFG_WIDTH_W-1:0]);
                REG_IMAGE_HEIGHT: r_h_eff <= clamp_height(i_cfg_data[CFG_HEIGHT_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        col_now = i_frame_start ? '0 : r_col;
        row_now = i_frame_start ? '0 : r_row;
        col_inc = {1'b0, col_now} + CWW'(1);
        row_inc = {1'b0, row_now} + CFG_HEIGHT_W'(1);
        w_last  = r_w_eff - CWW'(1);
        h_last  = r_h_eff - CFG_HEIGHT_W'(1);
        col_m1  = col_now - CW'(1);
        if (col_inc >= r_w_eff) begin
            n_col = '0;
            n_row = (row_inc >= r_h_eff) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col = col_inc[CW-1:0];
            n_row = row_now;
        end
        o_pos.emit = (row_now >= ROW_W'(2)) && (col_now >= CW'(2));
        o_pos.last = ({1'b0, row_now} == h_last) && ({1'b0, col_now} == w_last);
        o_pos.row  = row_now - ROW_W'(1);
        o_pos.col  = COL_W'(32'(col_m1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_addr = col_now;

endmodule

// ===== src/lbp3x3_window.sv =====
// 3x3 sliding window and LBP code compare for the LBP block.
// Depends on lbp3x3_pkg.
module lbp3x3_window (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [lbp3x3_pkg::PIXEL_W-1:0] i_up,
    input  logic [lbp3x3_pkg::PIXEL_W-1:0] i_mid,
    input  logic [lbp3x3_pkg::PIXEL_W-1:0] i_px,
    input  lbp3x3_pkg::t_pos               i_pos,
    output logic                           o_push,
    output lbp3x3_pkg::t_result            o_result
);
    import lbp3x3_pkg::*;

    // index 3*row+col, row 0 on top, col 2 newest
    logic [PIXEL_W-1:0] r_win [9];
    logic [PIXEL_W-1:0] ct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_valid) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= i_up;
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= i_mid;
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= i_px;
        end
    end

    // compare against the window as it stands after this shift
    always_comb begin
        ct = r_win[5];
        o_result.code[0] = ct > r_win[1];
        o_result.code[1] = ct > r_win[4];
        o_result.code[2] = ct > r_win[7];
        o_result.code[3] = ct > r_win[8];
        o_result.code[4] = ct > i_px;
        o_result.code[5] = ct > i_mid;
        o_result.code[6] = ct > i_up;
        o_result.code[7] = ct > r_win[2];
        o_result.row     = i_pos.row;
        o_result.col     = i_pos.col;
        o_result.last    = i_pos.last;
        o_push           = i_valid && i_pos.emit;
    end

endmodule

// ===== src/lbp3x3_out_fifo.sv =====
// Small result queue that parts the pipeline from the output handshake.
// Depends on lbp3x3_pkg.
module lbp3x3_out_fifo (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  lbp3x3_pkg::t_result               i_data,
    input  logic                              i_ready,
    output logic                              o_valid,
    output lbp3x3_pkg::t_result               o_data,
    output logic [lbp3x3_pkg::FIFO_CNT_W-1:0] o_count
);
    import lbp3x3_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    t_result               r_buf [FIFO_DEPTH];
    logic [AW-1:0]         r_wptr, r_rptr;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic                  pop;

    assign pop = (r_cnt != '0) && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + AW'(1);
            if (pop)    r_rptr <= r_rptr + AW'(1);
            r_cnt <= r_cnt + FIFO_CNT_W'(i_push) - FIFO_CNT_W'(pop);
        end
    end

    assign o_valid = r_cnt != '0;
    assign o_data  = r_buf[r_rptr];
    assign o_count = r_cnt;

endmodule

// ===== src/local_binary_pattern_3x3.sv =====
// A code is computed from the stage-1 registers and queued at the output before it leaves.
// Throughput: one pixel per cycle while not stalled; the line store is read in the accept
// cycle and written back in the next cycle, with forwarding when the same column repeats.
// Up to four codes queue at the output; input stalls when the queued codes plus the
// pixel in the window stage reach four.
// Reset: synchronous, active low; counters cleared, sizes 640x480, line store not cleared.
`include "local_binary_pattern_3x3_macros.svh"

module local_binary_pattern_3x3 #(
    parameter int MAX_WIDTH = lbp3x3_pkg::MAX_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lbp3x3_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lbp3x3_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [lbp3x3_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] pixel
    input  logic                               s_axis_tuser,  // [0] frame_start
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [lbp3x3_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [7:0] lbp_code,
                                                              // [19:8] centre_row,
                                                              // [30:20] centre_col
    output logic                               m_axis_tlast   // frame_last
);
    import lbp3x3_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WORD_W = 2 * PIXEL_W;

    logic                  acc;
    logic [CW-1:0]         rd_addr;
    t_pos                  pos;

    logic                  r_s1_v;
    logic [CW-1:0]         r_s1_addr;
    logic [PIXEL_W-1:0]    r_s1_px;
    t_pos                  r_s1_pos;
    logic                  r_fwd_hit;
    logic [WORD_W-1:0]     r_fwd_data;

    logic [WORD_W-1:0]     rdata, word, wdata;
    logic                  push;
    t_result               res, out_res;
    logic [FIFO_CNT_W-1:0] fifo_cnt;

    assign s_axis_tready = (fifo_cnt + FIFO_CNT_W'(r_s1_v)) < FIFO_CNT_W'(FIFO_DEPTH);
    assign acc           = s_axis_tvalid && s_axis_tready;

    lbp3x3_pos_ctr #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_advance     (acc),
        .i_frame_start (s_axis_tuser),
        .o_addr        (rd_addr),
        .o_pos         (pos)
    );

    // word = {upper, middle}
    lbp3x3_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_s1_v),
        .i_waddr (r_s1_addr),
        .i_wdata (wdata),
        .i_re    (acc),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    assign word  = r_fwd_hit ? r_fwd_data : rdata;
    assign wdata = {word[PIXEL_W-1:0], r_s1_px};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_s1_v    <= acc;
            r_fwd_hit <= acc && r_s1_v && (r_s1_addr == rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_addr <= rd_addr;
            r_s1_px   <= s_axis_tdata[PIXEL_W-1:0];
            r_s1_pos  <= pos;
        end
        r_fwd_data <= wdata;
    end

    lbp3x3_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_s1_v),
        .i_up     (word[WORD_W-1:PIXEL_W]),
        .i_mid    (word[PIXEL_W-1:0]),
        .i_px     (r_s1_px),
        .i_pos    (r_s1_pos),
        .o_push   (push),
        .o_result (res)
    );

    lbp3x3_out_fifo u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (out_res),
        .o_count (fifo_cnt)
    );

    assign m_axis_tdata = {1'b0, out_res.col, out_res.row, out_res.code};
    assign m_axis_tlast = out_res.last;

    `LBP_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, 1'b1, (fifo_cnt + FIFO_CNT_W'(r_s1_v)) <= FIFO_CNT_W'(FIFO_DEPTH))
    `LBP_ASSERT_SAME(a_fwd_needs_s1, i_clk, i_rst_n, r_fwd_hit, r_s1_v)
    `LBP_ASSERT_NEXT(a_emit_pushes, i_clk, i_rst_n, acc && pos.emit, push)
    `LBP_ASSERT_NEXT(a_frame_origin, i_clk, i_rst_n, acc && s_axis_tuser, (r_s1_addr == '0) && !r_s1_pos.emit)

endmodule
